@@ rtl/sntp_rv_pkg.sv @@
// ----------------------------------------------------------------------------
// sntp_rv_pkg
// Shared types and constants of the SNTP reply validator pipeline.
// ----------------------------------------------------------------------------
package sntp_rv_pkg;

  localparam logic [6:0] MIN_REPLY_LEN = 7'd48;
  localparam logic [2:0] MODE_SERVER   = 3'd4;
  localparam logic [7:0] MAX_STRATUM   = 8'd15;
  localparam logic [1:0] LEAP_ALARM    = 2'd3;

  // Configuration register indexes.
  localparam logic [7:0] CFG_MAX_ROOT_DIST = 8'd0;
  localparam logic [7:0] CFG_REF_SLOP      = 8'd1;
  localparam logic [7:0] CFG_DELAY_EPS     = 8'd2;

  localparam logic [47:0] MAX_ROOT_DIST_RST = 48'h0001_0000_0000;
  localparam logic [39:0] REF_SLOP_RST      = 40'h01_0000_0000;
  localparam logic [31:0] DELAY_EPS_RST     = 32'd4294967;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_SHORT    = 4'd1,
    ST_MODE     = 4'd2,
    ST_VERSION  = 4'd3,
    ST_ORIGIN   = 4'd4,
    ST_KOD      = 4'd5,
    ST_LEAP     = 4'd6,
    ST_STRATUM  = 4'd7,
    ST_RXZERO   = 4'd8,
    ST_XMTZERO  = 4'd9,
    ST_REFTIME  = 4'd10,
    ST_BADTIME  = 4'd11,
    ST_ROOTDIST = 4'd12
  } status_t;

  typedef struct packed {
    logic [47:0] max_root_distance;
    logic [39:0] reference_slop;
    logic [31:0] delay_epsilon;
  } cfg_regs_t;

  typedef struct packed {
    logic [6:0]  reply_length;
    logic [7:0]  header_byte;
    logic [7:0]  stratum_in;
    logic [31:0] root_delay;
    logic [31:0] root_dispersion;
    logic [63:0] reference_stamp;
    logic [63:0] originate_stamp;
    logic [63:0] receive_stamp;
    logic [63:0] transmit_stamp;
    logic [63:0] local_send;
    logic [63:0] local_receive;
    logic [63:0] request_nonce;
  } in_item_t;

  // After the header checks and the stamp differences.
  typedef struct packed {
    status_t     status;
    logic [7:0]  stratum;
    logic [63:0] d32;
    logic [63:0] d21;
    logic [63:0] d34;
    logic [63:0] d41;
    logic [63:0] dref;
    logic [31:0] root_delay;
    logic [31:0] root_dispersion;
  } s1_t;

  // After the reference check, raw delay and halved deltas.
  typedef struct packed {
    status_t     status;
    logic [7:0]  stratum;
    logic [64:0] delay_raw;
    logic [63:0] half21;
    logic [63:0] half34;
    logic [31:0] root_delay;
    logic [31:0] root_dispersion;
  } s2_t;

  // After the delay check, offset sum and root delay plus delay.
  typedef struct packed {
    status_t     status;
    logic [7:0]  stratum;
    logic [63:0] offset;
    logic [62:0] delay;
    logic [63:0] dist_sum;
    logic [31:0] root_dispersion;
  } s3_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  stratum;
    logic [63:0] clock_offset;
    logic [62:0] round_trip_delay;
    logic [63:0] root_distance;
  } res_t;

endpackage

@@ rtl/sntp_rv_cfg.sv @@
// ----------------------------------------------------------------------------
// sntp_rv_cfg
// Configuration registers: root distance bound, reference slop, delay epsilon.
// ----------------------------------------------------------------------------
module sntp_rv_cfg
  import sntp_rv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic [7:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output cfg_regs_t   regs
);

  cfg_regs_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.max_root_distance <= MAX_ROOT_DIST_RST;
      regs_r.reference_slop    <= REF_SLOP_RST;
      regs_r.delay_epsilon     <= DELAY_EPS_RST;
    end else if (cfg_valid) begin
      // Writes beyond the register list fall through and are dropped.
      if (cfg_index == CFG_MAX_ROOT_DIST) begin
        regs_r.max_root_distance <= cfg_data;
      end else if (cfg_index == CFG_REF_SLOP) begin
        regs_r.reference_slop <= cfg_data[39:0];
      end else if (cfg_index == CFG_DELAY_EPS) begin
        regs_r.delay_epsilon <= cfg_data[31:0];
      end
    end
  end

  assign regs = regs_r;

endmodule

@@ rtl/sntp_rv_diff.sv @@
// ----------------------------------------------------------------------------
// sntp_rv_diff
// Stage 1: header checks in priority order and the stamp differences.
// ----------------------------------------------------------------------------
module sntp_rv_diff
  import sntp_rv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  output logic     up_ready,
  input  in_item_t up_data,
  output logic     dn_valid,
  input  logic     dn_ready,
  output s1_t      dn_data
);

  logic    v1_r;
  s1_t     s1_r;
  s1_t     s1_nxt;
  status_t st;
  logic [2:0] mode;
  logic [2:0] ver;
  logic [1:0] leap;

  assign mode = up_data.header_byte[2:0];
  assign ver  = up_data.header_byte[5:3];
  assign leap = up_data.header_byte[7:6];

  always_comb begin
    if (up_data.reply_length < MIN_REPLY_LEN) begin
      st = ST_SHORT;
    end else if (mode != MODE_SERVER) begin
      st = ST_MODE;
    end else if (!(ver inside {[3'd1:3'd4]})) begin
      st = ST_VERSION;
    end else if (up_data.originate_stamp != up_data.request_nonce) begin
      st = ST_ORIGIN;
    end else if (up_data.stratum_in == 8'd0) begin
      st = ST_KOD;
    end else if (leap == LEAP_ALARM) begin
      st = ST_LEAP;
    end else if (up_data.stratum_in > MAX_STRATUM) begin
      st = ST_STRATUM;
    end else if (up_data.receive_stamp == 64'd0) begin
      st = ST_RXZERO;
    end else if (up_data.transmit_stamp == 64'd0) begin
      st = ST_XMTZERO;
    end else if (up_data.reference_stamp == 64'd0) begin
      st = ST_REFTIME;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    s1_nxt.status          = st;
    s1_nxt.stratum         = (st == ST_SHORT) ? 8'd0 : up_data.stratum_in;
    s1_nxt.d32             = up_data.transmit_stamp - up_data.receive_stamp;
    s1_nxt.d21             = up_data.receive_stamp - up_data.local_send;
    s1_nxt.d34             = up_data.transmit_stamp - up_data.local_receive;
    s1_nxt.d41             = up_data.local_receive - up_data.local_send;
    s1_nxt.dref            = up_data.reference_stamp - up_data.transmit_stamp;
    s1_nxt.root_delay      = up_data.root_delay;
    s1_nxt.root_dispersion = up_data.root_dispersion;
  end

  assign up_ready = !v1_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (up_ready) begin
      v1_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      s1_r <= s1_nxt;
    end
  end

  assign dn_valid = v1_r;
  assign dn_data  = s1_r;

endmodule

@@ rtl/sntp_rv_check.sv @@
// ----------------------------------------------------------------------------
// sntp_rv_check
// Stages 2 and 3: reference and timing checks, delay clamp, offset sum.
// ----------------------------------------------------------------------------
module sntp_rv_check
  import sntp_rv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_regs_t regs,
  input  logic      up_valid,
  output logic      up_ready,
  input  s1_t       up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output s3_t       dn_data
);

  logic v2_r;
  logic v3_r;
  s2_t  s2_r;
  s2_t  s2_nxt;
  s3_t  s3_r;
  s3_t  s3_nxt;
  logic ready2;
  logic ready3;
  logic ref_bad;
  logic [63:0] t21;
  logic [63:0] t34;
  logic [64:0] neg_eps;
  logic        delay_bad;
  logic [62:0] delay_clamped;
  logic [63:0] rdel;

  // Stage 2. Halving truncates toward zero: bias negatives by one first.
  always_comb begin
    ref_bad = $signed(up_data.dref) > $signed({24'd0, regs.reference_slop});
    t21     = up_data.d21 + {63'd0, up_data.d21[63]};
    t34     = up_data.d34 + {63'd0, up_data.d34[63]};

    if (up_data.status != ST_OK) begin
      s2_nxt.status = up_data.status;
    end else if (ref_bad) begin
      s2_nxt.status = ST_REFTIME;
    end else if (up_data.d32[63]) begin
      s2_nxt.status = ST_BADTIME;
    end else begin
      s2_nxt.status = ST_OK;
    end
    s2_nxt.stratum         = up_data.stratum;
    s2_nxt.delay_raw       = {up_data.d41[63], up_data.d41} - {up_data.d32[63], up_data.d32};
    s2_nxt.half21          = {t21[63], t21[63:1]};
    s2_nxt.half34          = {t34[63], t34[63:1]};
    s2_nxt.root_delay      = up_data.root_delay;
    s2_nxt.root_dispersion = up_data.root_dispersion;
  end

  // Stage 3. The 65-bit delay also catches the underflow case, since the
  // tolerance is far smaller than the signed 64-bit range.
  always_comb begin
    neg_eps       = 65'd0 - {33'd0, regs.delay_epsilon};
    delay_bad     = $signed(s2_r.delay_raw) < $signed(neg_eps);
    delay_clamped = s2_r.delay_raw[64] ? 63'd0 : s2_r.delay_raw[62:0];
    rdel          = s2_r.root_delay[31] ? 64'd0 : {16'd0, s2_r.root_delay, 16'd0};

    if (s2_r.status != ST_OK) begin
      s3_nxt.status = s2_r.status;
    end else if (delay_bad) begin
      s3_nxt.status = ST_BADTIME;
    end else begin
      s3_nxt.status = ST_OK;
    end
    s3_nxt.stratum         = s2_r.stratum;
    s3_nxt.offset          = s2_r.half21 + s2_r.half34;
    s3_nxt.delay           = delay_clamped;
    s3_nxt.dist_sum        = rdel + {1'b0, delay_clamped};
    s3_nxt.root_dispersion = s2_r.root_dispersion;
  end

  assign ready3   = !v3_r || dn_ready;
  assign ready2   = !v2_r || ready3;
  assign up_ready = ready2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ready2) begin
        v2_r <= up_valid;
      end
      if (ready3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && up_valid) begin
      s2_r <= s2_nxt;
    end
    if (ready3 && v2_r) begin
      s3_r <= s3_nxt;
    end
  end

  assign dn_valid = v3_r;
  assign dn_data  = s3_r;

endmodule

@@ rtl/sntp_rv_dist.sv @@
// ----------------------------------------------------------------------------
// sntp_rv_dist
// Stage 4: root distance with saturation, bound check and result register.
// ----------------------------------------------------------------------------
module sntp_rv_dist
  import sntp_rv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_regs_t regs,
  input  logic      up_valid,
  output logic      up_ready,
  input  s3_t       up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output res_t      dn_data
);

  logic v4_r;
  res_t res_r;
  res_t res_nxt;
  logic [64:0] total_wide;
  logic [63:0] total;
  logic [63:0] bound;
  logic        over;

  always_comb begin
    total_wide = {2'b00, up_data.dist_sum[63:1]}
               + {17'd0, up_data.root_dispersion, 16'd0};
    total      = total_wide[64] ? {64{1'b1}} : total_wide[63:0];
    bound      = {16'd0, regs.max_root_distance};
    // The dropped half unit still counts when the distance sits on the bound.
    over       = (total > bound) || ((total == bound) && up_data.dist_sum[0]);

    res_nxt.stratum = up_data.stratum;
    if (up_data.status != ST_OK) begin
      res_nxt.status           = up_data.status;
      res_nxt.clock_offset     = 64'd0;
      res_nxt.round_trip_delay = 63'd0;
      res_nxt.root_distance    = 64'd0;
    end else begin
      res_nxt.status           = over ? ST_ROOTDIST : ST_OK;
      res_nxt.clock_offset     = up_data.offset;
      res_nxt.round_trip_delay = up_data.delay;
      res_nxt.root_distance    = total;
    end
  end

  assign up_ready = !v4_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (up_ready) begin
      v4_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      res_r <= res_nxt;
    end
  end

  assign dn_valid = v4_r;
  assign dn_data  = res_r;

endmodule

@@ rtl/sntp_reply_validate.sv @@
// ----------------------------------------------------------------------------
// sntp_reply_validate
// SNTP server reply validator with offset, delay and root distance output.
// ----------------------------------------------------------------------------
// The block takes one parsed reply word per clock unless back-pressure stalls
// it and returns one result word per reply, in order. It has four register
// stages: header checks and stamp differences, reference check with the raw
// delay and halved deltas, delay check with the offset sum and root delay
// addition, and the root distance addition with its bound compare feeding the
// output register. Each stage holds its word under back-pressure and bubbles
// close up, so input is still accepted while a finished result waits, until
// the stages fill. The configuration registers are meant to be written only
// while the pipeline is empty; cfg_ready is always high and writes to indexes
// past the list are dropped.
// ----------------------------------------------------------------------------
module sntp_reply_validate
  import sntp_rv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // Reply input. Fields from the lowest bit up: reply_length[6:0],
  // header_byte[14:7], stratum_in[22:15], root_delay[54:23],
  // root_dispersion[86:55], reference_stamp[150:87], originate_stamp[214:151],
  // receive_stamp[278:215], transmit_stamp[342:279], local_send[406:343],
  // local_receive[470:407], request_nonce[534:471], zero pad [535].
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [535:0] in_tdata,
  // Result output. Fields from the lowest bit up: status[3:0],
  // stratum_out[11:4], clock_offset[75:12], round_trip_delay[138:76],
  // root_distance[202:139], zero pad [207:203].
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [207:0] out_tdata,
  // Configuration write: index 0 max_root_distance, 1 reference_slop,
  // 2 delay_epsilon; data is masked to the register width.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [47:0]  cfg_data
);

  cfg_regs_t regs;
  in_item_t  item;
  s1_t       s1_data;
  s3_t       s3_data;
  res_t      res;
  logic      s1_valid;
  logic      s1_ready;
  logic      s3_valid;
  logic      s3_ready;

  assign cfg_ready = 1'b1;

  // Unpack the input word.
  assign item.reply_length    = in_tdata[6:0];
  assign item.header_byte     = in_tdata[14:7];
  assign item.stratum_in      = in_tdata[22:15];
  assign item.root_delay      = in_tdata[54:23];
  assign item.root_dispersion = in_tdata[86:55];
  assign item.reference_stamp = in_tdata[150:87];
  assign item.originate_stamp = in_tdata[214:151];
  assign item.receive_stamp   = in_tdata[278:215];
  assign item.transmit_stamp  = in_tdata[342:279];
  assign item.local_send      = in_tdata[406:343];
  assign item.local_receive   = in_tdata[470:407];
  assign item.request_nonce   = in_tdata[534:471];

  sntp_rv_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  // Stage 1: header checks and differences of the timestamps.
  sntp_rv_diff u_diff (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (item),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  // Stages 2 and 3: reference and timing checks, delay clamp and offset.
  sntp_rv_check u_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .regs     (regs),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s3_valid),
    .dn_ready (s3_ready),
    .dn_data  (s3_data)
  );

  // Stage 4: root distance, bound check and the output register.
  sntp_rv_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .regs     (regs),
    .up_valid (s3_valid),
    .up_ready (s3_ready),
    .up_data  (s3_data),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (res)
  );

  assign out_tdata = {5'd0, res.root_distance, res.round_trip_delay,
                      res.clock_offset, res.stratum, res.status};

endmodule

@@ tb/sntp_reply_validate_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sntp_reply_validate_chk
// Passive checker: shadows the configuration registers, predicts the verdict
// of every accepted reply word and compares it with the result words in order.
// ----------------------------------------------------------------------------
module sntp_reply_validate_chk
  import sntp_rv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [535:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [207:0] out_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [47:0]  cfg_data,
  output int           mismatches,
  output int           outstanding
);

  localparam logic signed [63:0] I64_MIN = 64'sh8000_0000_0000_0000;

  logic [47:0] max_rdist;
  logic [39:0] ref_slop;
  logic [31:0] delay_eps;
  res_t        expected_verdicts[$];
  int          fail_count;

  function automatic res_t judge_reply(input in_item_t r);
    res_t               v;
    logic signed [63:0] d32, d21, d34, d41, dref, del, neg_eps;
    logic [63:0]        rdel, sum, half;
    logic [64:0]        total;
    logic [2:0]         ver;
    v = '0;
    if (r.reply_length < MIN_REPLY_LEN) begin
      v.status = ST_SHORT;
      return v;
    end
    v.stratum = r.stratum_in;
    ver = r.header_byte[5:3];
    // Stamp differences wrap modulo 2^64 and are read as signed values.
    d32 = r.transmit_stamp - r.receive_stamp;
    d21 = r.receive_stamp - r.local_send;
    d34 = r.transmit_stamp - r.local_receive;
    d41 = r.local_receive - r.local_send;
    dref = r.reference_stamp - r.transmit_stamp;
    neg_eps = -$signed({32'd0, delay_eps});
    del = d41 - d32;
    if (r.header_byte[2:0] != MODE_SERVER) v.status = ST_MODE;
    else if (ver < 3'd1 || ver > 3'd4) v.status = ST_VERSION;
    else if (r.originate_stamp != r.request_nonce) v.status = ST_ORIGIN;
    else if (r.stratum_in == 8'd0) v.status = ST_KOD;
    else if (r.header_byte[7:6] == LEAP_ALARM) v.status = ST_LEAP;
    else if (r.stratum_in > MAX_STRATUM) v.status = ST_STRATUM;
    else if (r.receive_stamp == 64'd0) v.status = ST_RXZERO;
    else if (r.transmit_stamp == 64'd0) v.status = ST_XMTZERO;
    else if (r.reference_stamp == 64'd0 || dref > $signed({24'd0, ref_slop}))
      v.status = ST_REFTIME;
    else if (d32 < 0 || d41 < I64_MIN + d32 || del < neg_eps) v.status = ST_BADTIME;
    if (v.status != ST_OK) return v;

    if (del < 0) del = '0;
    v.clock_offset = d21 / 2 + d34 / 2;
    v.round_trip_delay = del[62:0];
    // A negative root delay counts as zero; 16.16 values move up to 32.32.
    rdel = r.root_delay[31] ? 64'd0 : {16'd0, r.root_delay, 16'd0};
    sum = rdel + del;
    half = sum >> 1;
    total = {1'b0, half} + {17'd0, r.root_dispersion, 16'd0};
    v.root_distance = total[64] ? '1 : total[63:0];
    // The dropped half unit still counts when the distance sits on the bound.
    if (v.root_distance > {16'd0, max_rdist} ||
        (v.root_distance == {16'd0, max_rdist} && sum[0]))
      v.status = ST_ROOTDIST;
    return v;
  endfunction

  always @(posedge clk) begin : watch
    in_item_t reply;
    res_t     seen, want;
    if (!rst_n) begin
      max_rdist = MAX_ROOT_DIST_RST;
      ref_slop = REF_SLOP_RST;
      delay_eps = DELAY_EPS_RST;
      expected_verdicts.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_ROOT_DIST: max_rdist = cfg_data;
          CFG_REF_SLOP:      ref_slop = cfg_data[39:0];
          CFG_DELAY_EPS:     delay_eps = cfg_data[31:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        seen = {out_tdata[3:0], out_tdata[11:4], out_tdata[75:12],
                out_tdata[138:76], out_tdata[202:139]};
        if (expected_verdicts.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result word with no reply pending: %h", out_tdata);
        end else begin
          want = expected_verdicts.pop_front();
          if (seen !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch: expected st=%0d strat=%0d off=%h dly=%h dist=%h, ",
                        "actual st=%0d strat=%0d off=%h dly=%h dist=%h"},
                       want.status, want.stratum, want.clock_offset,
                       want.round_trip_delay, want.root_distance,
                       seen.status, seen.stratum, seen.clock_offset,
                       seen.round_trip_delay, seen.root_distance);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        reply = {in_tdata[6:0], in_tdata[14:7], in_tdata[22:15], in_tdata[54:23],
                 in_tdata[86:55], in_tdata[150:87], in_tdata[214:151],
                 in_tdata[278:215], in_tdata[342:279], in_tdata[406:343],
                 in_tdata[470:407], in_tdata[534:471]};
        expected_verdicts.push_back(judge_reply(reply));
      end
    end
    mismatches <= fail_count;
    outstanding <= expected_verdicts.size();
  end

endmodule

@@ tb/sntp_reply_validate_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sntp_reply_validate_tb
// Drives parsed SNTP replies and configuration writes into the validator,
// with random idling on both sides, a long output stall and a full drain,
// while a separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module sntp_reply_validate_tb;
  import sntp_rv_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // Fields from the lowest bit up: reply_length, header_byte, stratum_in,
  // root_delay, root_dispersion, reference_stamp, originate_stamp,
  // receive_stamp, transmit_stamp, local_send, local_receive, request_nonce.
  logic [535:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  // Fields from the lowest bit up: status, stratum_out, clock_offset,
  // round_trip_delay, root_distance.
  logic [207:0] out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [7:0]   cfg_index;
  logic [47:0]  cfg_data;

  int mismatch_count;
  int replies_in_flight;

  // When calm is set neither side idles. A hold request makes the receiver
  // refuse result words for a long stretch that it counts itself.
  bit calm;
  bit hold_req;

  sntp_reply_validate dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  sntp_reply_validate_chk chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatch_count),
    .outstanding (replies_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The run can never legally take this long, so reaching it means a hang.
  initial begin
    #(12 * 400000);
    $display("Regression FAIL");
    $finish;
  end

  // Receiver: random back-pressure, or a counted hold-off on request.
  initial begin : rx_side
    int hold_left;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 90;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else begin
        out_tready = calm || ($urandom_range(0, 99) >= 18);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one reply word, possibly after a short random gap, and return at
  // the falling edge after it was taken. Valid stays high for a following word.
  task automatic send_reply(input in_item_t r);
    int gap;
    if (!calm && $urandom_range(0, 99) < 7) begin
      in_tvalid = 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {1'b0, r.request_nonce, r.local_receive, r.local_send, r.transmit_stamp,
                r.receive_stamp, r.originate_stamp, r.reference_stamp,
                r.root_dispersion, r.root_delay, r.stratum_in, r.header_byte,
                r.reply_length};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait until every result word has come back.
  task automatic drain_replies();
    in_tvalid = 1'b0;
    wait (replies_in_flight == 0);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [47:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hand-picked replies. Case 0 is a clean exchange; the others each break
  // or stretch one rule of the check order, using the reset configuration.
  function automatic in_item_t directed_reply(input int k);
    in_item_t r;
    r.reply_length = MIN_REPLY_LEN;
    r.header_byte = {2'd0, 3'd4, MODE_SERVER};
    r.stratum_in = 8'd2;
    r.root_delay = 32'h0000_1000;
    r.root_dispersion = 32'h0000_0800;
    r.request_nonce = 64'h0123_4567_89AB_CDEF;
    r.originate_stamp = r.request_nonce;
    r.local_send = 64'hE000_0000_0000_0000;
    r.receive_stamp = r.local_send + 64'h4000_0000;
    r.transmit_stamp = r.receive_stamp + 64'h1000_0000;
    r.local_receive = r.transmit_stamp + 64'h4000_0000;
    r.reference_stamp = r.transmit_stamp - 64'h1_0000_0000;
    case (k)
      1: r.reply_length = MIN_REPLY_LEN - 7'd1;
      2: begin
        r = '1;
        r.reply_length = 7'd0;
      end
      3: r.reply_length = 7'd112;
      4: r.header_byte[2:0] = 3'd3;
      5: r.header_byte[5:3] = 3'd0;
      6: r.header_byte[5:3] = 3'd5;
      7: r.originate_stamp = r.request_nonce ^ 64'h8000_0000_0000_0000;
      8: r.stratum_in = 8'd0;
      9: r.header_byte[7:6] = LEAP_ALARM;
      10: r.stratum_in = MAX_STRATUM + 8'd1;
      11: r.stratum_in = 8'hFF;
      12: r.receive_stamp = 64'd0;
      13: r.transmit_stamp = 64'd0;
      14: r.reference_stamp = 64'd0;
      // Reference exactly at the slop passes, one unit more fails.
      15: r.reference_stamp = r.transmit_stamp + 64'h1_0000_0000;
      16: r.reference_stamp = r.transmit_stamp + 64'h1_0000_0001;
      17: r.transmit_stamp = r.receive_stamp - 64'd1;
      // Client round trip of exactly minus 2^63 underflows the delay.
      18: r.local_receive = r.local_send + 64'h8000_0000_0000_0000;
      // Slightly negative delays: at the tolerance it clamps, past it fails.
      19: r.local_receive = r.local_send + (r.transmit_stamp - r.receive_stamp)
                            - 64'd4294967;
      20: r.local_receive = r.local_send + (r.transmit_stamp - r.receive_stamp)
                            - 64'd4294968;
      // Root distance lands on the one-second bound with and without a half unit.
      21, 22: begin
        r.root_delay = 32'd0;
        r.root_dispersion = 32'd0;
        r.local_receive = r.local_send + (r.transmit_stamp - r.receive_stamp)
                          + ((k == 21) ? 64'h2_0000_0001 : 64'h2_0000_0000);
      end
      23: begin
        r.root_delay = 32'h8000_0000;
        r.root_dispersion = 32'hFFFF_FFFF;
      end
      // Era rollover with odd deltas of both signs for the halving.
      24: begin
        r.local_send = 64'hFFFF_FFFF_F000_0000;
        r.receive_stamp = r.local_send + 64'h3FFF_FFFD;
        r.transmit_stamp = r.receive_stamp + 64'h1000_0000;
        r.local_receive = r.transmit_stamp + 64'h4000_0003;
        r.reference_stamp = r.transmit_stamp - 64'd1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Mostly plausible exchanges with random timing, a quarter of them with one
  // rule broken, and a tenth of pure noise that sets every bit at random.
  function automatic in_item_t make_reply();
    in_item_t           r;
    logic signed [63:0] skew;
    logic [63:0]        out_leg, back_leg, proc;
    int                 pick;
    pick = $urandom_range(0, 99);
    r.reply_length = 7'($urandom_range(0, 112));
    r.header_byte = 8'($urandom);
    r.stratum_in = 8'($urandom);
    r.root_delay = $urandom;
    r.root_dispersion = $urandom;
    r.reference_stamp = rand64();
    r.originate_stamp = rand64();
    r.receive_stamp = rand64();
    r.transmit_stamp = rand64();
    r.local_send = rand64();
    r.local_receive = rand64();
    r.request_nonce = rand64();
    if (pick < 10) return r;

    r.reply_length = 7'($urandom_range(48, 112));
    r.header_byte[7:6] = 2'($urandom_range(0, 2));
    r.header_byte[5:3] = 3'($urandom_range(1, 4));
    r.header_byte[2:0] = MODE_SERVER;
    r.stratum_in = 8'($urandom_range(1, 15));
    r.originate_stamp = r.request_nonce;
    if ($urandom_range(0, 7) == 0)
      r.local_send = 64'hFFFF_FFFF_0000_0000 + {32'd0, $urandom};
    skew = $signed(rand64()) >>> $urandom_range(20, 62);
    out_leg = rand64() >> $urandom_range(30, 44);
    back_leg = rand64() >> $urandom_range(30, 44);
    proc = rand64() >> $urandom_range(20, 44);
    r.receive_stamp = r.local_send + out_leg + skew;
    r.transmit_stamp = r.receive_stamp + proc;
    r.local_receive = r.transmit_stamp + back_leg - skew;
    // Small negative round trips straddle the tolerance.
    if ($urandom_range(0, 99) < 15)
      r.local_receive = r.local_send + proc
                        - {32'd0, ($urandom >> $urandom_range(0, 31))};
    if ($urandom_range(0, 9) == 0)
      r.reference_stamp = r.transmit_stamp + (rand64() >> $urandom_range(24, 40));
    else
      r.reference_stamp = r.transmit_stamp - (rand64() >> $urandom_range(24, 60));
    if ($urandom_range(0, 9) == 0) r.root_delay = $urandom | 32'h8000_0000;
    else r.root_delay = $urandom >> $urandom_range(12, 31);
    r.root_dispersion = $urandom >> $urandom_range(14, 31);

    if (pick < 35) begin
      case ($urandom_range(0, 12))
        0: r.reply_length = 7'($urandom_range(0, 47));
        1: r.header_byte[2:0] = MODE_SERVER ^ 3'($urandom_range(1, 7));
        2: r.header_byte[5:3] = $urandom_range(0, 1) ? 3'd0 : 3'($urandom_range(5, 7));
        3: r.originate_stamp = r.request_nonce ^ (64'd1 << $urandom_range(0, 63));
        4: r.stratum_in = 8'd0;
        5: r.header_byte[7:6] = LEAP_ALARM;
        6: r.stratum_in = 8'($urandom_range(16, 255));
        7: r.receive_stamp = 64'd0;
        8: r.transmit_stamp = 64'd0;
        9: r.reference_stamp = 64'd0;
        10: r.transmit_stamp = r.receive_stamp - 64'd1 - {32'd0, ($urandom >> 4)};
        11: r.local_receive = r.local_send + 64'h8000_0000_0000_0000
                              + {32'd0, ($urandom >> 8)};
        default: r.local_receive = r.local_send + (rand64() >> 1);
      endcase
    end
    return r;
  endfunction

  initial begin : stimulus
    int k, n, phase;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed words run with the registers still at their reset values.
    for (k = 0; k < 25; k++) send_reply(directed_reply(k));

    for (phase = 0; phase < 6; phase++) begin
      // Registers change only with the pipeline empty.
      drain_replies();
      case (phase)
        0: begin
          // All ones everywhere, so the wider data also checks the masking.
          write_reg(CFG_MAX_ROOT_DIST, '1);
          write_reg(CFG_REF_SLOP, '1);
          write_reg(CFG_DELAY_EPS, '1);
          write_reg(CFG_DELAY_EPS + 8'd1 + 8'($urandom_range(0, 252)), 48'($urandom));
        end
        1: begin
          write_reg(CFG_MAX_ROOT_DIST, '0);
          write_reg(CFG_REF_SLOP, '0);
          write_reg(CFG_DELAY_EPS, '0);
        end
        2, 5: begin
          write_reg(CFG_MAX_ROOT_DIST, MAX_ROOT_DIST_RST);
          write_reg(CFG_REF_SLOP, {8'd0, REF_SLOP_RST});
          write_reg(CFG_DELAY_EPS, {16'd0, DELAY_EPS_RST});
        end
        default: begin
          write_reg(CFG_MAX_ROOT_DIST, 48'(rand64() >> $urandom_range(16, 40)));
          write_reg(CFG_REF_SLOP, 48'(rand64() >> $urandom_range(24, 48)));
          write_reg(CFG_DELAY_EPS, 48'($urandom >> $urandom_range(0, 16)));
        end
      endcase
      // One whole phase runs with no idling on either side.
      calm = (phase == 4);
      for (n = 0; n < 220; n++) begin
        // The receiver stalls long enough for the pipeline to fill and push
        // back on the input, while words keep being offered.
        if (phase == 2 && n == 60) hold_req = 1'b1;
        if (phase == 2 && n == 150) drain_replies();
        send_reply(make_reply());
      end
    end

    in_tvalid = 1'b0;
    wait (replies_in_flight == 0);
    // Keep running in case the block emits a word nobody asked for.
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && replies_in_flight == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/sntp_rv_pkg.sv
rtl/sntp_rv_cfg.sv
rtl/sntp_rv_diff.sv
rtl/sntp_rv_check.sv
rtl/sntp_rv_dist.sv
rtl/sntp_reply_validate.sv
tb/sntp_reply_validate_chk.sv
tb/sntp_reply_validate_tb.sv
